// ===== rtl/mme_pkg.sv =====
// ----------------------------------------------------------------------------
// Modular multiply and exponentiation package
// Shared state encoding and field codes for the modular multiply/power unit.
// ----------------------------------------------------------------------------
package mme_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_GO,
        S_RED_WAIT,
        S_MUL_GO,
        S_MUL_WAIT,
        S_EMUL_GO,
        S_EMUL_WAIT,
        S_ESQR_GO,
        S_ESQR_WAIT,
        S_WB
    } t_state;

    localparam logic MODE_MUL = 1'b0;
    localparam logic MODE_POW = 1'b1;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_DOMAIN = 1'b1;

endpackage

// ===== rtl/mme_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one operand set into the unit.
// ----------------------------------------------------------------------------
interface mme_req_if #(
    parameter int WIDTH = 64
) ();
    logic             valid;
    logic             ready;
    logic             mode;
    logic [WIDTH-1:0] base_value;
    logic [WIDTH-1:0] second_operand;
    logic [WIDTH-1:0] modulus;

    modport source (
        output valid, mode, base_value, second_operand, modulus,
        input  ready
    );

    modport sink (
        input  valid, mode, base_value, second_operand, modulus,
        output ready
    );
endinterface

// ===== rtl/mme_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result and its status out of the unit.
// ----------------------------------------------------------------------------
interface mme_rsp_if #(
    parameter int WIDTH = 64
) ();
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] result_value;
    logic             status;

    modport source (
        output valid, result_value, status,
        input  ready
    );

    modport sink (
        input  valid, result_value, status,
        output ready
    );
endinterface

// ===== rtl/mme_reduce.sv =====
// ----------------------------------------------------------------------------
// Bit-serial modular reduction
// Computes dividend mod modulus by restoring division, one dividend bit per
// cycle, most significant bit first.
// ----------------------------------------------------------------------------
module mme_reduce #(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_modulus,
    output logic             o_done,
    output logic [WIDTH-1:0] o_rem
);
    localparam int CNT_W = $clog2(WIDTH);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [WIDTH-1:0] r_dvd;
    logic [WIDTH-1:0] r_mod;
    logic [WIDTH-1:0] r_rem;

    logic [WIDTH:0]   n_trial;
    logic [WIDTH-1:0] n_rem;

    always_comb begin
        n_trial = {r_rem, r_dvd[WIDTH-1]};
        if (n_trial >= {1'b0, r_mod}) begin
            n_rem = WIDTH'(n_trial - {1'b0, r_mod});
        end else begin
            n_rem = n_trial[WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_W'(WIDTH - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_dvd <= i_dividend;
            r_mod <= i_modulus;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[WIDTH-2:0], 1'b0};
            r_rem <= n_rem;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/mme_modmul.sv =====
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Shift-and-add multiply that scans the multiplier one bit per cycle, least
// significant bit first, reducing the accumulator and the doubled addend in
// every step. The multiplicand must already be below the modulus.
// ----------------------------------------------------------------------------
module mme_modmul #(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic [WIDTH-1:0] i_modulus,
    output logic             o_done,
    output logic [WIDTH-1:0] o_prod
);
    localparam int CNT_W = $clog2(WIDTH);

    function automatic logic [WIDTH-1:0] add_mod(
        input logic [WIDTH-1:0] x,
        input logic [WIDTH-1:0] y,
        input logic [WIDTH-1:0] m
    );
        logic [WIDTH:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[WIDTH-1:0];
    endfunction

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_add;
    logic [WIDTH-1:0] r_mul;
    logic [WIDTH-1:0] r_mod;

    logic [WIDTH-1:0] n_acc;
    logic [WIDTH-1:0] n_add;

    always_comb begin
        n_acc = r_mul[0] ? add_mod(r_acc, r_add, r_mod) : r_acc;
        n_add = add_mod(r_add, r_add, r_mod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_W'(WIDTH - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_acc <= '0;
            r_add <= i_a;
            r_mul <= i_b;
            r_mod <= i_modulus;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_add <= n_add;
            r_mul <= {1'b0, r_mul[WIDTH-1:1]};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== rtl/modular_mul_exp_unit.sv =====
// Multiply mode runs one reduction and one modular product; power mode runs
// one reduction, then a modular square per exponent bit up to the highest set
// bit and a modular multiply per set bit, all on the bit-serial multiplier.
// Out-of-domain inputs go straight to writeback. One item is in flight at a
// time; a finished result waits in the output register. Synchronous active-low
// reset returns the unit to idle and drops any pending result.
// ----------------------------------------------------------------------------
// Modular multiply and exponentiation unit
// Sequencer for modular multiply and right-to-left square-and-multiply power,
// built on a bit-serial reducer and a bit-serial modular multiplier.
// ----------------------------------------------------------------------------
module modular_mul_exp_unit #(
    parameter int WIDTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mme_req_if.sink    i_req,
    mme_rsp_if.source  o_rsp
);
    mme_pkg::t_state r_state;
    mme_pkg::t_state n_state;

    logic             r_mode;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_e;
    logic [WIDTH-1:0] r_m;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_sq;
    logic [WIDTH-1:0] r_res;
    logic             r_st;
    logic             r_out_valid;
    logic [WIDTH-1:0] r_out_res;
    logic             r_out_st;

    logic             req_fire;
    logic             dom_err;
    logic             red_start;
    logic             red_done;
    logic [WIDTH-1:0] red_rem;
    logic             mul_start;
    logic             mul_done;
    logic [WIDTH-1:0] mul_a;
    logic [WIDTH-1:0] mul_b;
    logic [WIDTH-1:0] mul_prod;
    logic             wb_load;

    assign dom_err = (i_req.modulus <= WIDTH'(1)) || (i_req.base_value == '0)
                     || (i_req.second_operand == '0);

    mme_reduce #(
        .WIDTH (WIDTH)
    ) u_reduce (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (red_start),
        .i_dividend (r_a),
        .i_modulus  (r_m),
        .o_done     (red_done),
        .o_rem      (red_rem)
    );

    mme_modmul #(
        .WIDTH (WIDTH)
    ) u_modmul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .i_modulus (r_m),
        .o_done    (mul_done),
        .o_prod    (mul_prod)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            mme_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_state = dom_err ? mme_pkg::S_WB : mme_pkg::S_RED_GO;
                end
            end
            mme_pkg::S_RED_GO: begin
                n_state = mme_pkg::S_RED_WAIT;
            end
            mme_pkg::S_RED_WAIT: begin
                if (red_done) begin
                    if (r_mode == mme_pkg::MODE_MUL) begin
                        n_state = mme_pkg::S_MUL_GO;
                    end else if (r_e[0]) begin
                        n_state = mme_pkg::S_EMUL_GO;
                    end else begin
                        n_state = mme_pkg::S_ESQR_GO;
                    end
                end
            end
            mme_pkg::S_MUL_GO: begin
                n_state = mme_pkg::S_MUL_WAIT;
            end
            mme_pkg::S_MUL_WAIT: begin
                if (mul_done) begin
                    n_state = mme_pkg::S_WB;
                end
            end
            mme_pkg::S_EMUL_GO: begin
                n_state = mme_pkg::S_EMUL_WAIT;
            end
            mme_pkg::S_EMUL_WAIT: begin
                if (mul_done) begin
                    n_state = mme_pkg::S_ESQR_GO;
                end
            end
            mme_pkg::S_ESQR_GO: begin
                n_state = mme_pkg::S_ESQR_WAIT;
            end
            mme_pkg::S_ESQR_WAIT: begin
                if (mul_done) begin
                    if (r_e[WIDTH-1:1] == '0) begin
                        n_state = mme_pkg::S_WB;
                    end else if (r_e[1]) begin
                        n_state = mme_pkg::S_EMUL_GO;
                    end else begin
                        n_state = mme_pkg::S_ESQR_GO;
                    end
                end
            end
            mme_pkg::S_WB: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = mme_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mme_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        i_req.ready = 1'b0;
        red_start   = 1'b0;
        mul_start   = 1'b0;
        mul_a       = r_sq;
        mul_b       = r_sq;
        wb_load     = 1'b0;
        case (r_state)
            mme_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
            end
            mme_pkg::S_RED_GO: begin
                red_start = 1'b1;
            end
            mme_pkg::S_MUL_GO: begin
                mul_start = 1'b1;
                mul_b     = r_e;
            end
            mme_pkg::S_EMUL_GO: begin
                mul_start = 1'b1;
                mul_a     = r_acc;
            end
            mme_pkg::S_ESQR_GO: begin
                mul_start = 1'b1;
            end
            mme_pkg::S_WB: begin
                wb_load = !r_out_valid || o_rsp.ready;
            end
            default: begin
                i_req.ready = 1'b0;
            end
        endcase
    end

    assign req_fire = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mme_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wb_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_mode <= i_req.mode;
            r_a    <= i_req.base_value;
            r_e    <= i_req.second_operand;
            r_m    <= i_req.modulus;
            r_res  <= '0;
            r_st   <= dom_err ? mme_pkg::STATUS_DOMAIN : mme_pkg::STATUS_OK;
        end
        if ((r_state == mme_pkg::S_RED_WAIT) && red_done) begin
            r_sq  <= red_rem;
            r_acc <= WIDTH'(1);
        end
        if ((r_state == mme_pkg::S_MUL_WAIT) && mul_done) begin
            r_res <= mul_prod;
        end
        if ((r_state == mme_pkg::S_EMUL_WAIT) && mul_done) begin
            r_acc <= mul_prod;
        end
        if ((r_state == mme_pkg::S_ESQR_WAIT) && mul_done) begin
            r_sq  <= mul_prod;
            r_e   <= {1'b0, r_e[WIDTH-1:1]};
            r_res <= r_acc;
        end
        if (wb_load) begin
            r_out_res <= r_res;
            r_out_st  <= r_st;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_out_res;
    assign o_rsp.status       = r_out_st;

endmodule
